// File: hdl/plsk_pkg.sv
// types, codes and constants shared by the pooled linked stack modules
package plsk_pkg;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // value left in a freed slot
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // input transaction payload
  typedef struct packed {
    logic       req_type;
    logic [7:0] item;
  } req_t;

  // output transaction payload
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic [7:0] removed_item;
    logic       head_valid;
    logic [3:0] head_slot;
  } rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the request and launch the link and element reads
    logic commit;  // update heads, write the stores and load the result
  } cmd_t;

endpackage

// File: hdl/plsk_ctrl.sv
// controller state machine for the pooled linked stack
module plsk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output plsk_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   commit;

  // handshake and commands
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign commit      = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.commit = commit;

  // next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/plsk_dp.sv
// datapath: slot stores, list and free heads, result register
module plsk_dp #(
  parameter int SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plsk_pkg::cmd_t cmd_i,
  input  plsk_pkg::req_t in_req_i,
  output plsk_pkg::rsp_t out_rsp_o
);

  localparam int IW = $clog2(SLOTS);

  // stores: element bytes and links (valid bit over index)
  logic [7:0]  elem_mem [SLOTS];
  logic [IW:0] link_mem [SLOTS];

  // heads and count of never-used slots (slots below it are untouched)
  logic [IW-1:0] free_head_q, free_head_d;
  logic          free_ok_q, free_ok_d;
  logic [IW-1:0] list_head_q, list_head_d;
  logic          list_ok_q, list_ok_d;
  logic [IW:0]   fresh_q, fresh_d;

  plsk_pkg::req_t req_q;
  plsk_pkg::rsp_t rsp_q, rsp_d;
  logic [IW:0]    link_rd_q;
  logic [7:0]     elem_rd_q;
  logic [IW-1:0]  rd_addr;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_elem;
  logic [IW:0]   wr_link;

  // low four bits of a slot index, zero extended when narrower
  function automatic logic [3:0] lo4(input logic [IW-1:0] v);
    logic [IW+3:0] e;
    e = (IW+4)'(v);
    return e[3:0];
  endfunction

  assign rd_addr = (in_req_i.req_type == plsk_pkg::REQ_INSERT) ? free_head_q : list_head_q;

  // operation on the latched request and the read data
  always_comb begin
    free_head_d = free_head_q;
    free_ok_d   = free_ok_q;
    list_head_d = list_head_q;
    list_ok_d   = list_ok_q;
    fresh_d     = fresh_q;
    wr_en       = 1'b0;
    wr_addr     = free_head_q;
    wr_elem     = req_q.item;
    wr_link     = {list_ok_q, list_head_q};
    rsp_d       = '0;
    if (req_q.req_type == plsk_pkg::REQ_INSERT) begin
      if (!free_ok_q) begin
        rsp_d.status = plsk_pkg::STATUS_FULL;
      end else begin
        // pop the free front; an untouched slot links to the one below it
        if ({1'b0, free_head_q} < fresh_q) begin
          free_head_d = free_head_q - 1'b1;
          free_ok_d   = (free_head_q != '0);
          fresh_d     = {1'b0, free_head_q};
        end else begin
          free_head_d = link_rd_q[IW-1:0];
          free_ok_d   = link_rd_q[IW];
        end
        wr_en        = 1'b1;
        wr_addr      = free_head_q;
        wr_elem      = req_q.item;
        wr_link      = {list_ok_q, list_head_q};
        list_head_d  = free_head_q;
        list_ok_d    = 1'b1;
        rsp_d.status = plsk_pkg::STATUS_DONE;
        rsp_d.slot   = lo4(free_head_q);
      end
    end else begin
      if (!list_ok_q) begin
        rsp_d.status = plsk_pkg::STATUS_EMPTY;
      end else begin
        // unlink the list front and push it on the free list
        list_head_d        = link_rd_q[IW-1:0];
        list_ok_d          = link_rd_q[IW];
        wr_en              = 1'b1;
        wr_addr            = list_head_q;
        wr_elem            = plsk_pkg::SPACE_CHAR;
        wr_link            = {free_ok_q, free_head_q};
        free_head_d        = list_head_q;
        free_ok_d          = 1'b1;
        rsp_d.status       = plsk_pkg::STATUS_DONE;
        rsp_d.slot         = lo4(list_head_q);
        rsp_d.removed_item = elem_rd_q;
      end
    end
    rsp_d.head_valid = list_ok_d;
    rsp_d.head_slot  = list_ok_d ? lo4(list_head_d) : 4'd0;
  end

  // head registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= IW'(SLOTS - 1);
      free_ok_q   <= 1'b1;
      list_head_q <= '0;
      list_ok_q   <= 1'b0;
      fresh_q     <= (IW+1)'(SLOTS);
    end else if (cmd_i.commit) begin
      free_head_q <= free_head_d;
      free_ok_q   <= free_ok_d;
      list_head_q <= list_head_d;
      list_ok_q   <= list_ok_d;
      fresh_q     <= fresh_d;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  // store reads at accept, writes at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      link_rd_q <= link_mem[rd_addr];
      elem_rd_q <= elem_mem[list_head_q];
    end
    if (cmd_i.commit && wr_en) begin
      link_mem[wr_addr] <= wr_link;
      elem_mem[wr_addr] <= wr_elem;
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

// File: hdl/pooled_linked_stack.sv
// top level of the pooled linked stack: controller plus datapath
//
//  channel  signals                         transaction
//  in       in_valid_i, in_stall_o, in_req_i   one insert or delete request
//  out      out_valid_o, out_stall_i, out_rsp_o one result per request
//
// each request reads the link and element from the slot stores in the accept
// cycle, then updates the heads and writes the stores at commit.
// a finished result waits in the output register; the next request is taken
// while it waits, and its commit holds until that register is free.
// reset sets the heads and the count of untouched slots only, so no
// clearing pass runs and requests are taken right after reset.
module pooled_linked_stack #(
  parameter int SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plsk_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plsk_pkg::rsp_t out_rsp_o
);

  plsk_pkg::cmd_t cmd;

  // sequencing and handshake
  plsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // slot stores and heads
  plsk_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o)
  );

endmodule
